// ----- src/tmcw_pkg.sv -----
// Shared definitions for the text console writer: screen geometry, character and
// attribute codes, the input and result item types and the controller state type.
// No dependencies; the controller, the top level and the testbench import this package.
package tmcw_pkg;

    // Screen geometry.
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;

    // Field widths of the items.
    localparam int MODE_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int TICK_W  = 32;

    // Screen store addressing: a physical row index beside a column index.
    localparam int COL_IDX_W = $clog2(COLUMNS);
    localparam int ROW_IDX_W = $clog2(ROWS);
    localparam int ADDR_W    = ROW_IDX_W + COL_IDX_W;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    // Width of the sum of the base-64 digits of the tick count.
    localparam int SUM_W        = 9;
    localparam int BLINK_PERIOD = 9;

    localparam logic [COL_W-1:0]     LAST_COL     = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]     COL_LIMIT    = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0]     PARK_ROW     = ROW_W'(ROWS);
    localparam logic [COL_IDX_W-1:0] LAST_COL_IDX = COL_IDX_W'(COLUMNS - 1);
    localparam logic [ROW_IDX_W-1:0] LAST_ROW_IDX = ROW_IDX_W'(ROWS - 1);

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PRINT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOME  = 3'd4;

    // Character and attribute codes.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_MARK  = 8'h5F;

    localparam logic [ATTR_W-1:0] ATTR_NONE    = 8'h00;
    localparam logic [ATTR_W-1:0] ATTR_DEFAULT = 8'h07;
    localparam logic [ATTR_W-1:0] ATTR_WHITE   = 8'h0F;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CHAR_W-1:0]  char_code;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic               advance;
        logic [ROW_W-1:0]   read_row;
        logic [COL_W-1:0]   read_col;
        logic [TICK_W-1:0]  tick_count;
    } item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } result_t;

    // Handshake status from the controller to the top level.
    typedef struct packed {
        logic can_take;
        logic res_valid;
    } stat_t;

    // Screen store requests: a write and a read.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_READ_DATA,
        S_TICK_CHECK,
        S_PUT,
        S_SCROLL,
        S_DONE
    } ctrl_state_t;

endpackage

// ----- src/tmcw_ram.sv -----
// Simple dual-port RAM holding the character cells of the screen.
// One write port and one read port with registered read data; no dependencies.
module tmcw_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W) - 1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/tmcw_ctrl.sv -----
// Sequencer of the text console writer: cursor, scroll offset, print, clear and
// scroll walks, and all requests to the screen store. Depends on tmcw_pkg.
module tmcw_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  tmcw_pkg::item_t           item,
    input  logic                      cursor_enable,
    input  logic                      res_taken,
    output tmcw_pkg::stat_t           stat,
    output tmcw_pkg::result_t         res,
    output tmcw_pkg::ram_req_t        ram_req,
    input  logic [tmcw_pkg::CELL_W-1:0] ram_rd_data
);
    import tmcw_pkg::*;

    // Physical row of a logical row, given the scroll offset.
    function automatic logic [ROW_IDX_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                      input logic [ROW_IDX_W-1:0] base);
        logic [ROW_W:0] sum;
        sum = {1'b0, row} + (ROW_W + 1)'(base);
        if (sum >= (ROW_W + 1)'(ROWS))
        begin
            sum = sum - (ROW_W + 1)'(ROWS);
        end
        return sum[ROW_IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return {prow, col[COL_IDX_W-1:0]};
    endfunction

    // Since 64 leaves a remainder of 1 modulo 9, the sum of the base-64 digits
    // keeps the remainder of the tick count.
    function automatic logic [SUM_W-1:0] digit_sum(input logic [TICK_W-1:0] ticks);
        logic [SUM_W-1:0] s;
        s = SUM_W'(ticks[31:30]);
        for (int i = 0; i < 5; i++)
        begin
            s = s + SUM_W'(ticks[6*i +: 6]);
        end
        return s;
    endfunction

    function automatic logic mod9_zero(input logic [SUM_W-1:0] s);
        logic [6:0] r;
        logic       hit;
        r   = 7'(s[5:0]) + 7'(s[8:6]);
        hit = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            if (r == 7'(k * BLINK_PERIOD))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    ctrl_state_t            state_reg, state_next;
    logic                   init_reg, init_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_IDX_W-1:0]   base_reg, base_next;
    logic [ROW_IDX_W-1:0]   walk_row_reg, walk_row_next;
    logic [COL_IDX_W-1:0]   walk_col_reg, walk_col_next;
    logic [ROW_IDX_W-1:0]   fill_row_reg, fill_row_next;
    logic [CHAR_W-1:0]      put_ch_reg, put_ch_next;
    logic [ATTR_W-1:0]      put_attr_reg, put_attr_next;
    logic                   put_adv_reg, put_adv_next;
    logic                   put_line_reg, put_line_next;
    logic [1:0]             put_cnt_reg, put_cnt_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   even_reg, even_next;
    logic [CHAR_W-1:0]      res_char_reg, res_char_next;
    logic [ATTR_W-1:0]      res_attr_reg, res_attr_next;

    logic             accept;
    logic             parked;
    logic [COL_W-1:0] step_col;
    logic [ROW_W-1:0] step_row;
    logic [COL_W-1:0] put_col;
    logic             put_last;
    logic             clear_last;
    logic             rd_in_range;

    assign accept      = item_valid && stat.can_take;
    assign parked      = (row_reg >= PARK_ROW);
    assign step_col    = (col_reg >= LAST_COL) ? '0 : col_reg + 1'b1;
    assign step_row    = (col_reg >= LAST_COL) ? row_reg + 1'b1 : row_reg;
    assign put_col     = put_adv_reg ? step_col : col_reg;
    assign put_last    = put_line_reg ? (put_col == '0) : (put_cnt_reg == 2'd1);
    assign clear_last  = (walk_row_reg == LAST_ROW_IDX) && (walk_col_reg == LAST_COL_IDX);
    assign rd_in_range = (item.read_row < PARK_ROW) && (item.read_col < COL_LIMIT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_PRINT:
                        begin
                            if (item.char_code == CH_BS && col_reg == '0 && row_reg == '0)
                                state_next = S_DONE;
                            else
                                state_next = S_PUT;
                        end
                        MODE_READ:
                            state_next = rd_in_range ? S_READ_DATA : S_DONE;
                        MODE_TICK:
                            state_next = cursor_enable ? S_TICK_CHECK : S_DONE;
                        MODE_CLEAR:
                            state_next = S_CLEAR;
                        default:
                            state_next = S_DONE;
                    endcase
                end
                else if (state_reg == S_DONE && res_taken)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                if (clear_last)
                    state_next = init_reg ? S_IDLE : S_DONE;
            end
            S_READ_DATA:
                state_next = S_DONE;
            S_TICK_CHECK:
                state_next = mod9_zero(sum_reg) ? S_PUT : S_DONE;
            S_PUT:
            begin
                if (parked)
                    state_next = S_SCROLL;
                else if (put_last)
                    state_next = S_DONE;
            end
            S_SCROLL:
            begin
                if (walk_col_reg == LAST_COL_IDX)
                    state_next = S_PUT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Outputs: handshake status, result and store requests.
    always_comb
    begin
        stat.can_take   = (state_reg == S_IDLE) || (state_reg == S_DONE && res_taken);
        stat.res_valid  = (state_reg == S_DONE);
        res.cell_char   = res_char_reg;
        res.cell_attr   = res_attr_reg;
        res.cursor_col  = col_reg;
        res.cursor_row  = row_reg;
        ram_req         = '0;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept && item.mode == MODE_READ && rd_in_range)
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = cell_addr(phys_row(item.read_row, base_reg),
                                                item.read_col);
                end
            end
            S_CLEAR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = {walk_row_reg, walk_col_reg};
                ram_req.wr_data = {ATTR_DEFAULT, CH_BLANK};
            end
            S_PUT:
            begin
                if (!parked)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = cell_addr(phys_row(row_reg, base_reg), col_reg);
                    ram_req.wr_data = {put_attr_reg, put_ch_reg};
                end
            end
            S_SCROLL:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = {fill_row_reg, walk_col_reg};
                ram_req.wr_data = {ATTR_NONE, CH_BLANK};
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        init_next     = init_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        walk_row_next = walk_row_reg;
        walk_col_next = walk_col_reg;
        fill_row_next = fill_row_reg;
        put_ch_next   = put_ch_reg;
        put_attr_next = put_attr_reg;
        put_adv_next  = put_adv_reg;
        put_line_next = put_line_reg;
        put_cnt_next  = put_cnt_reg;
        sum_next      = sum_reg;
        even_next     = even_reg;
        res_char_next = res_char_reg;
        res_attr_next = res_attr_reg;
        case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (accept)
                begin
                    res_char_next = '0;
                    res_attr_next = '0;
                    case (item.mode)
                        MODE_PRINT:
                        begin
                            put_line_next = 1'b0;
                            put_cnt_next  = 2'd1;
                            if (item.char_code == CH_BS)
                            begin
                                // Backspace moves first, then blanks the new cell.
                                put_ch_next   = CH_BLANK;
                                put_attr_next = ATTR_WHITE;
                                put_adv_next  = 1'b0;
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                else if (row_reg != '0)
                                begin
                                    row_next = row_reg - 1'b1;
                                    col_next = LAST_COL;
                                end
                            end
                            else if (item.char_code == CH_NL)
                            begin
                                put_ch_next   = CH_BLANK;
                                put_attr_next = ATTR_DEFAULT;
                                put_adv_next  = 1'b1;
                                put_line_next = 1'b1;
                            end
                            else if (item.char_code == CH_TAB)
                            begin
                                put_ch_next   = CH_BLANK;
                                put_attr_next = {item.bg_color, item.fg_color};
                                put_adv_next  = 1'b1;
                                put_cnt_next  = 2'd2;
                            end
                            else
                            begin
                                put_ch_next   = item.char_code;
                                put_attr_next = {item.bg_color, item.fg_color};
                                put_adv_next  = item.advance;
                            end
                        end
                        MODE_TICK:
                        begin
                            sum_next  = digit_sum(item.tick_count);
                            even_next = ~item.tick_count[0];
                        end
                        MODE_CLEAR:
                        begin
                            walk_row_next = '0;
                            walk_col_next = '0;
                            row_next      = '0;
                            col_next      = '0;
                            base_next     = '0;
                        end
                        MODE_HOME:
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        default:
                        begin
                            res_char_next = '0;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                if (walk_col_reg == LAST_COL_IDX)
                begin
                    walk_col_next = '0;
                    walk_row_next = clear_last ? '0 : walk_row_reg + 1'b1;
                end
                else
                begin
                    walk_col_next = walk_col_reg + 1'b1;
                end
                if (clear_last)
                begin
                    init_next = 1'b0;
                end
            end
            S_READ_DATA:
            begin
                res_char_next = ram_rd_data[CHAR_W-1:0];
                res_attr_next = ram_rd_data[CELL_W-1:CHAR_W];
            end
            S_TICK_CHECK:
            begin
                // A multiple of 18 erases the mark, an odd multiple of 9 draws it.
                put_ch_next   = even_reg ? CH_BLANK : CH_MARK;
                put_attr_next = ATTR_WHITE;
                put_adv_next  = 1'b0;
                put_line_next = 1'b0;
                put_cnt_next  = 2'd1;
            end
            S_PUT:
            begin
                if (parked)
                begin
                    // Scroll by rotating the row offset; the old top row becomes
                    // the new bottom row and is blanked by the walk.
                    fill_row_next = base_reg;
                    base_next     = (base_reg == LAST_ROW_IDX) ? '0 : base_reg + 1'b1;
                    row_next      = row_reg - 1'b1;
                    walk_col_next = '0;
                end
                else
                begin
                    col_next     = put_col;
                    row_next     = put_adv_reg ? step_row : row_reg;
                    put_cnt_next = put_cnt_reg - 1'b1;
                end
            end
            S_SCROLL:
            begin
                walk_col_next = walk_col_reg + 1'b1;
            end
            default:
            begin
                init_next = init_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            init_reg     <= 1'b1;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            walk_row_reg <= '0;
            walk_col_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_reg     <= init_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            walk_row_reg <= walk_row_next;
            walk_col_reg <= walk_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_row_reg <= fill_row_next;
        put_ch_reg   <= put_ch_next;
        put_attr_reg <= put_attr_next;
        put_adv_reg  <= put_adv_next;
        put_line_reg <= put_line_next;
        put_cnt_reg  <= put_cnt_next;
        sum_reg      <= sum_next;
        even_reg     <= even_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
    end

endmodule

// ----- src/text_mode_console_writer.sv -----
// Text console writer. Prints, tabs, newlines, scrolls and clears write their cells through the
// single write port of the screen store, one cell per cycle: a tab two cells, a newline up to
// COLUMNS, each scroll COLUMNS more and a clear ROWS * COLUMNS. A home or a read writes none.
// After reset the block blanks the ROWS * COLUMNS screen cells of the store before it
// takes an item; the cursor is home and cursor drawing is off. Config writes are taken always.
module text_mode_console_writer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  tmcw_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output tmcw_pkg::result_t result,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data
);
    import tmcw_pkg::*;

    stat_t             stat;
    result_t           res;
    ram_req_t          ram_req;
    logic [CELL_W-1:0] ram_rd_data;
    logic              res_taken;

    logic    cursor_enable_reg;
    logic    result_valid_reg;
    result_t result_reg;

    // The controller owns the cursor and the scroll offset and drives every
    // access to the screen store. Scrolling rotates a row offset instead of
    // moving cells, so only the new bottom row has to be written.
    tmcw_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item          (item),
        .cursor_enable (cursor_enable_reg),
        .res_taken     (res_taken),
        .stat          (stat),
        .res           (res),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data)
    );

    // Screen store: one cell per address, a physical row beside a column.
    tmcw_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    // A finished result moves into the output register whenever that register
    // is empty or being emptied in the same cycle. The controller can take the
    // next item in that same cycle, so the output side never holds it up
    // unless the output register is full and stalled.
    assign res_taken = stat.res_valid && (!result_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_enable_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cursor_enable_reg <= cfg_wr_data;
            end
            if (res_taken)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
        begin
            result_reg <= res;
        end
    end

    assign item_stall   = !stat.can_take;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The cursor never goes further than the parking row below the screen.
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.cursor_row <= PARK_ROW)
        else $error("cursor row beyond the parking row");

    // A parked cursor always sits at the first column.
    a_park_col: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.cursor_row == PARK_ROW) |-> result.cursor_col == '0)
        else $error("parked cursor not at the first column");

    // The controller keeps a finished result until the output register takes it.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.res_valid && !res_taken) |=> stat.res_valid)
        else $error("finished result dropped before it was taken");

    // A result handed over shows up at the output in the next cycle.
    a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
        res_taken |=> result_valid)
        else $error("result handed over but not presented");

endmodule

// ----- sim/tb_text_mode_console_writer.sv -----
// Self-checking testbench for the text console writer: directed and random print, read,
// blink, clear and home items, with random idling on both handshakes and a receiver hold-off.
// Depends on tmcw_pkg and text_mode_console_writer only; it reads and writes no files.
module tb_text_mode_console_writer;
    timeunit 1ns;
    timeprecision 1ps;
    import tmcw_pkg::*;

    // The longest quiet stretch of a correct run is a clear (one cell per cycle over all screen
    // cells) behind a stalled result, or the receiver hold-off; this is several times that.
    localparam int IDLE_LIMIT      = 20000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 190;
    localparam int SETTLE_CYCLES   = 20;
    localparam int REPORT_LIMIT    = 10;

    // Modes with no operation behind them; the block must leave its state alone.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Cursor drawing setting for each random phase, bit p for phase p.
    localparam logic [PHASES-1:0] BLINK_PLAN = 10'b1011010110;

    // The screen store, the cursor and the blink enable, kept in step with every item
    // that the block accepts, and the queue of results that those items must produce.
    class console_scoreboard;
        logic [CELL_W-1:0] cells [ROWS][COLUMNS];
        int unsigned       row;
        int unsigned       col;
        bit                blink_on;
        result_t           due_reports[$];
        int                errors;

        function new();
            fill_blank();
            row      = 0;
            col      = 0;
            blink_on = 1'b0;
            errors   = 0;
        endfunction

        function void fill_blank();
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLUMNS; c++)
                    cells[r][c] = {ATTR_DEFAULT, CH_BLANK};
        endfunction

        // Moves every row up by one; the freed bottom row holds blanks with no attribute.
        function void scroll_up();
            for (int r = 1; r < ROWS; r++)
                for (int c = 0; c < COLUMNS; c++)
                    cells[r-1][c] = cells[r][c];
            for (int c = 0; c < COLUMNS; c++)
                cells[ROWS-1][c] = {ATTR_NONE, CH_BLANK};
            row--;
        endfunction

        // Writes one cell at the cursor, scrolling first when the cursor is parked below
        // the last row, then steps the cursor when asked to.
        function void put_cell(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr, bit step);
            if (row >= ROWS)
                scroll_up();
            cells[row][col] = {attr, ch};
            if (step)
            begin
                if (col >= COLUMNS - 1)
                begin
                    col = 0;
                    row++;
                end
                else
                    col++;
            end
        endfunction

        function result_t console_step(item_t it);
            result_t            res;
            logic [ATTR_W-1:0]  attr;
            res  = '0;
            attr = {it.bg_color, it.fg_color};
            case (it.mode)
                MODE_PRINT:
                begin
                    if (it.char_code == CH_BS)
                    begin
                        // Backspace wraps to the end of the row above, but not above row 0.
                        if (col == 0)
                        begin
                            if (row > 0)
                            begin
                                row--;
                                col = COLUMNS - 1;
                                put_cell(CH_BLANK, ATTR_WHITE, 1'b0);
                            end
                        end
                        else
                        begin
                            col--;
                            put_cell(CH_BLANK, ATTR_WHITE, 1'b0);
                        end
                    end
                    else
                    begin
                        if (row >= ROWS)
                            scroll_up();
                        if (it.char_code == CH_NL)
                        begin
                            do
                                put_cell(CH_BLANK, ATTR_DEFAULT, 1'b1);
                            while (col != 0);
                        end
                        else if (it.char_code == CH_TAB)
                        begin
                            put_cell(CH_BLANK, attr, 1'b1);
                            put_cell(CH_BLANK, attr, 1'b1);
                        end
                        else
                            put_cell(it.char_code, attr, it.advance);
                    end
                end
                MODE_READ:
                begin
                    if (it.read_row < ROWS && it.read_col < COLUMNS)
                        {res.cell_attr, res.cell_char} = cells[it.read_row][it.read_col];
                end
                MODE_TICK:
                begin
                    if (blink_on)
                    begin
                        if (it.tick_count % (2 * BLINK_PERIOD) == 0)
                            put_cell(CH_BLANK, ATTR_WHITE, 1'b0);
                        else if (it.tick_count % BLINK_PERIOD == 0)
                            put_cell(CH_MARK, ATTR_WHITE, 1'b0);
                    end
                end
                MODE_CLEAR:
                begin
                    fill_blank();
                    row = 0;
                    col = 0;
                end
                MODE_HOME:
                begin
                    row = 0;
                    col = 0;
                end
                default: ;
            endcase
            res.cursor_col = COL_W'(col);
            res.cursor_row = ROW_W'(row);
            return res;
        endfunction

        function void note_item(item_t it);
            due_reports.push_back(console_step(it));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_reports.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR %0t: result %02h/%02h at %0d,%0d with no item pending",
                             $time, got.cell_char, got.cell_attr, got.cursor_col,
                             got.cursor_row);
                return;
            end
            want = due_reports.pop_front();
            if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
                got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR %0t: expected %02h/%02h at %0d,%0d, got %02h/%02h at %0d,%0d",
                             $time, want.cell_char, want.cell_attr, want.cursor_col,
                             want.cursor_row, got.cell_char, got.cell_attr,
                             got.cursor_col, got.cursor_row);
            end
        endfunction

        function int pending();
            return due_reports.size();
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item_in;
    logic    result_valid;
    logic    result_stall;
    result_t result_out;
    logic    cfg_wr_en;
    logic    cfg_wr_data;

    console_scoreboard sb;

    // Idling controls shared by the driving processes. A calm side never idles; the
    // hold-off request makes the receiver stall long enough for the block to back up.
    bit send_calm;
    bit recv_calm;
    bit hold_off_req;

    text_mode_console_writer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic item_t mk_item(logic [MODE_W-1:0] mode, logic [CHAR_W-1:0] ch,
                                      logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg,
                                      logic adv, logic [ROW_W-1:0] rd_row,
                                      logic [COL_W-1:0] rd_col, logic [TICK_W-1:0] ticks);
        item_t it;
        it.mode       = mode;
        it.char_code  = ch;
        it.fg_color   = fg;
        it.bg_color   = bg;
        it.advance    = adv;
        it.read_row   = rd_row;
        it.read_col   = rd_col;
        it.tick_count = ticks;
        return it;
    endfunction

    // Random item. Fill phases are dominated by printing with many newlines, never clear and
    // home only seldom, so the cursor reaches the bottom and parks, and the screen scrolls.
    // Mixed phases spread the weight over all operations. Unused fields stay random.
    function automatic item_t random_item(bit fill);
        item_t it;
        int    pick;
        int    kind;
        int    base;
        it   = {$urandom, $urandom};
        pick = $urandom_range(0, 999);
        kind = $urandom_range(0, 99);
        if (pick < (fill ? 800 : 550))
        begin
            it.mode = MODE_PRINT;
            if (kind < (fill ? 25 : 8))
                it.char_code = CH_NL;
            else if (kind < (fill ? 33 : 16))
                it.char_code = CH_TAB;
            else if (kind < (fill ? 43 : 30))
                it.char_code = CH_BS;
            else if (fill)
                it.advance = ($urandom_range(0, 4) != 0);
        end
        else if (pick < (fill ? 920 : 800))
        begin
            it.mode = MODE_READ;
            if (kind < 50)
            begin
                // Look at the rows that are being written right now.
                base = (sb.row >= ROWS) ? ROWS - 1 : int'(sb.row);
                if ($urandom_range(0, 1) == 1 && base > 0)
                    base--;
                it.read_row = ROW_W'(base);
                it.read_col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
            else if (kind < 90)
            begin
                it.read_row = ROW_W'($urandom_range(0, ROWS - 1));
                it.read_col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
            else if (kind < 95)
                it.read_row = ROW_W'($urandom_range(ROWS, (1 << ROW_W) - 1));
            else
                it.read_col = COL_W'($urandom_range(COLUMNS, (1 << COL_W) - 1));
        end
        else if (pick < (fill ? 980 : 910))
        begin
            it.mode = MODE_TICK;
            // Hit the erase and the draw points of the blink cycle, not just the misses.
            if (kind < 30)
                it.tick_count = ($urandom % 32'd238609294) * 32'd18;
            else if (kind < 60)
                it.tick_count = (($urandom % 32'd477218588) | 32'd1) * 32'd9;
        end
        else if (pick < (fill ? 990 : 940))
            it.mode = MODE_HOME;
        else if (!fill && pick < 950)
            it.mode = MODE_CLEAR;
        else
            it.mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        return it;
    endfunction

    // Offers one item after a random gap and returns at the edge that takes it. The task is
    // entered between falling edges, so valid is either kept high with a new payload or
    // lowered for the gap, never both in one step.
    task automatic offer(input item_t it);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item_in    <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Writes the cursor drawing register once the block has delivered everything it owes.
    task automatic set_cursor_enable(input bit on);
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        sb.blink_on = on;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: a random stall before each result, or the long hold-off when requested.
    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold         = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                hold = recv_calm ? 0 : $urandom_range(0, 15);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            sb.check_result(result_out);
        end
    end

    // Watchdog: ends the run when neither channel has moved an item for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_text_mode_console_writer NOT OK");
        $finish;
    end

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item_in      = '0;
        result_stall = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        hold_off_req = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, cursor drawing off as after reset. The block first blanks its
        // store, which the handshake simply waits out.
        offer(mk_item(MODE_PRINT, 8'h41, 4'hF, 4'hF, 1'b1, 5'd0, 7'd0, 32'd0));
        // Stored without advancing, then overwritten by the next print.
        offer(mk_item(MODE_PRINT, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_PRINT, 8'hFF, 4'h3, 4'hC, 1'b1, 5'd0, 7'd0, 32'd0));
        // A tab advances two cells even with advance low.
        offer(mk_item(MODE_PRINT, CH_TAB, 4'h1, 4'h2, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_PRINT, CH_BS, 4'h5, 4'h6, 1'b1, 5'd0, 7'd0, 32'd0));
        // Newline mid-row pads to the end; at column 0 it pads the whole row.
        offer(mk_item(MODE_PRINT, CH_NL, 4'h5, 4'h6, 1'b1, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_PRINT, CH_NL, 4'h5, 4'h6, 1'b0, 5'd0, 7'd0, 32'd0));
        // Backspace at column 0 of a lower row wraps to the last column above.
        offer(mk_item(MODE_PRINT, CH_BS, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd1, 32'd0));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd1, 7'd79, 32'd0));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd24, 7'd79, 32'd0));
        // Reads off the screen return zero cell fields.
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd31, 7'd127, 32'd0));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd25, 7'd0, 32'd0));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd80, 32'd0));
        // A tick with cursor drawing off does nothing, nor do the unused modes.
        offer(mk_item(MODE_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_SPARE_LO, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_SPARE_HI, 8'hFF, 4'hF, 4'hF, 1'b1, 5'd31, 7'd127, 32'hFFFFFFFF));
        offer(mk_item(MODE_HOME, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        // Backspace at the top left corner stays put.
        offer(mk_item(MODE_PRINT, CH_BS, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));

        // Blink: erase on a full period, underscore on a half period, nothing otherwise.
        set_cursor_enable(1'b1);
        offer(mk_item(MODE_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd18));
        offer(mk_item(MODE_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd9));
        offer(mk_item(MODE_TICK, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd5));
        offer(mk_item(MODE_READ, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));
        offer(mk_item(MODE_CLEAR, 8'h00, 4'h0, 4'h0, 1'b0, 5'd0, 7'd0, 32'd0));

        // Random phases. Phase 3 runs with no idling on either side; in phase 6 the
        // sender never idles while the receiver holds off, so the block backs up.
        for (int p = 0; p < PHASES; p++)
        begin
            set_cursor_enable(BLINK_PLAN[p]);
            send_calm    = (p == 3) || (p == 6);
            recv_calm    = (p == 3);
            hold_off_req = (p == 6);
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer(random_item(p % 2 == 0));
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_text_mode_console_writer OK");
        else
            $display("tb_text_mode_console_writer NOT OK");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/tmcw_pkg.sv
src/tmcw_ram.sv
src/tmcw_ctrl.sv
src/text_mode_console_writer.sv
sim/tb_text_mode_console_writer.sv
